/* src/fafp_pkg.sv */
// ----------------------------------------------------------------------------
// Four-anchor placement package
// Shared widths, status codes and the records that flow between the
// front end, the queue and the back end of the placement core.
// ----------------------------------------------------------------------------
package fafp_pkg;

  localparam int CAP_W = 30;   // distances are capped to 2^30 - 1
  localparam int SQ_W  = 60;   // a squared distance
  localparam int DEN_W = 31;   // twice a distance or twice a root
  localparam int Q1_W  = 62;   // magnitude of the X numerators
  localparam int Q2_W  = 64;   // magnitude of the fourth Y numerator

  localparam logic [CAP_W-1:0] CAP_MAX = '1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_BASE = 3'd1,
    ST_RAD3_NEG  = 3'd2,
    ST_Y3_ZERO   = 3'd3,
    ST_RAD4_NEG  = 3'd4,
    ST_SAT       = 3'd5
  } status_e;

  // Clamped distances and their squares, as queued between the two halves.
  typedef struct packed {
    logic [CAP_W-1:0] d12;
    logic [CAP_W-1:0] d13;
    logic [CAP_W-1:0] d14;
    logic [SQ_W-1:0]  sq12;
    logic [SQ_W-1:0]  sq13;
    logic [SQ_W-1:0]  sq23;
    logic [SQ_W-1:0]  sq14;
    logic [SQ_W-1:0]  sq24;
    logic [SQ_W-1:0]  sq34;
  } dist_t;

  // Working record carried down the back-end pipeline.
  typedef struct packed {
    logic [CAP_W-1:0] d12;
    logic [CAP_W-1:0] d13;
    logic [CAP_W-1:0] d14;
    logic [SQ_W-1:0]  sq13;
    logic [SQ_W-1:0]  sq14;
    logic [SQ_W-1:0]  sq34;
    logic             x3_s;
    logic [CAP_W-1:0] x3_m;
    logic             x4_s;
    logic [CAP_W-1:0] x4_m;
    logic             e2;
    logic             e3;
    logic             e4;
    logic [SQ_W-1:0]  px3;
    logic [SQ_W-1:0]  px4;
    logic [SQ_W-1:0]  pxx;
    logic             pxx_s;
    logic [CAP_W-1:0] y3;
    logic [SQ_W-1:0]  py3;
    logic             y4_s;
    logic [CAP_W-1:0] y4_m;
    logic [SQ_W-1:0]  py4;
  } ctx_t;

endpackage

/* src/fafp_front.sv */
// ----------------------------------------------------------------------------
// Placement front end
// Accepts a distance set, clamps each distance and squares it.
// ----------------------------------------------------------------------------
module fafp_front #(
  parameter int DIST_BITS = 16,
  localparam int TDATA_W = ((6 * DIST_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,
  output logic                 valid_o,
  output fafp_pkg::dist_t      data_o,
  input  logic                 ready_i
);
  import fafp_pkg::*;

  localparam int XW = (DIST_BITS > CAP_W) ? DIST_BITS : CAP_W;

  logic             v_q;
  dist_t            data_q;
  dist_t            data_d;
  logic [CAP_W-1:0] d [6];

  function automatic logic [CAP_W-1:0] clamp_dist(input logic [DIST_BITS-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    if (e > XW'(CAP_MAX)) begin
      return CAP_MAX;
    end
    return e[CAP_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d[i] = clamp_dist(s_axis_tdata[i*DIST_BITS +: DIST_BITS]);
    end
    data_d.d12  = d[0];
    data_d.d13  = d[1];
    data_d.d14  = d[3];
    data_d.sq12 = SQ_W'(d[0]) * SQ_W'(d[0]);
    data_d.sq13 = SQ_W'(d[1]) * SQ_W'(d[1]);
    data_d.sq23 = SQ_W'(d[2]) * SQ_W'(d[2]);
    data_d.sq14 = SQ_W'(d[3]) * SQ_W'(d[3]);
    data_d.sq24 = SQ_W'(d[4]) * SQ_W'(d[4]);
    data_d.sq34 = SQ_W'(d[5]) * SQ_W'(d[5]);
  end

  assign s_axis_tready = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (s_axis_tready) begin
      v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

/* src/fafp_queue.sv */
// ----------------------------------------------------------------------------
// Placement queue
// Four-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fafp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fafp_pkg::dist_t data_i,
  output logic            valid_o,
  input  logic            rd_i,
  output fafp_pkg::dist_t data_o
);
  import fafp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  dist_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             full, empty, push, pop;

  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign push    = valid_i && !full;
  assign pop     = rd_i && !empty;
  assign ready_o = !full;
  assign valid_o = !empty;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

/* src/fafp_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the numerator register fills with the
// quotient as it shifts. Carries a sideband word alongside.
// ----------------------------------------------------------------------------
module fafp_div #(
  parameter int NUM_W  = 62,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [NUM_W];
  logic [NUM_W-1:0]  nq_q   [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  logic              v_in   [NUM_W];
  logic [NUM_W-1:0]  n_in   [NUM_W];
  logic [DEN_W-1:0]  r_in   [NUM_W];
  logic [DEN_W-1:0]  d_in   [NUM_W];
  logic [SIDE_W-1:0] s_in   [NUM_W];
  logic [NUM_W-1:0]  nq_d   [NUM_W];
  logic [DEN_W-1:0]  rem_d  [NUM_W];

  always_comb begin
    v_in[0] = valid_i;
    n_in[0] = num_i;
    r_in[0] = '0;
    d_in[0] = den_i;
    s_in[0] = side_i;
    for (int k = 1; k < NUM_W; k++) begin
      v_in[k] = v_q[k-1];
      n_in[k] = nq_q[k-1];
      r_in[k] = rem_q[k-1];
      d_in[k] = den_q[k-1];
      s_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [DEN_W:0] trial;
    logic           ge;
    for (int k = 0; k < NUM_W; k++) begin
      trial    = {r_in[k], n_in[k][NUM_W-1]};
      ge       = (trial >= {1'b0, d_in[k]});
      nq_d[k]  = {n_in[k][NUM_W-2:0], ge};
      rem_d[k] = ge ? DEN_W'(trial - {1'b0, d_in[k]}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_W; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q   <= nq_d;
      rem_q  <= rem_d;
      den_q  <= d_in;
      side_q <= s_in;
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_o   = nq_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

/* src/fafp_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor root, one result bit per stage, with a sideband
// word carried alongside.
// ----------------------------------------------------------------------------
module fafp_isqrt #(
  parameter int RAD_W  = 60,
  parameter int SIDE_W = 1,
  localparam int ROOT_W = RAD_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = ROOT_W + 2;

  logic              v_q    [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [RW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  logic              v_in    [ROOT_W];
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  logic [RW-1:0]     rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [SIDE_W-1:0] s_in    [ROOT_W];
  logic [RAD_W-1:0]  rad_d   [ROOT_W];
  logic [RW-1:0]     rem_d   [ROOT_W];
  logic [ROOT_W-1:0] root_d  [ROOT_W];

  always_comb begin
    v_in[0]    = valid_i;
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    s_in[0]    = side_i;
    for (int k = 1; k < ROOT_W; k++) begin
      v_in[k]    = v_q[k-1];
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      s_in[k]    = side_q[k-1];
    end
  end

  // The remainder never exceeds twice the partial root, so RW bits hold it.
  always_comb begin
    logic [RW+1:0] remsh;
    logic [RW+1:0] trial;
    logic          ge;
    for (int k = 0; k < ROOT_W; k++) begin
      remsh     = {rem_in[k], rad_in[k][RAD_W-1 -: 2]};
      trial     = (RW+2)'({root_in[k], 2'b01});
      ge        = (remsh >= trial);
      rem_d[k]  = ge ? RW'(remsh - trial) : RW'(remsh);
      root_d[k] = {root_in[k][ROOT_W-2:0], ge};
      rad_d[k]  = {rad_in[k][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROOT_W; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= s_in;
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

/* src/fafp_back.sv */
// ----------------------------------------------------------------------------
// Placement back end
// Runs the closed-form equations through dividers and root units,
// classifies errors, saturates and holds the result for the receiver.
// ----------------------------------------------------------------------------
module fafp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fafp_pkg::dist_t data_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [103:0]    m_axis_tdata,   // second_x, third_x, third_y, fourth_x,
                                          // fourth_y, fourth_z, 2 zero bits
  output logic [2:0]      m_axis_tuser    // status
);
  import fafp_pkg::*;

  localparam int CTX_W = $bits(ctx_t);

  logic en;

  // Stage A: numerators of both X equations.
  logic                 a_v_q;
  ctx_t                 a_ctx_q, a_ctx_d;
  logic [Q1_W-1:0]      a_num3_q, a_num4_q, a_num3_d, a_num4_d;
  logic                 a_s4_q;
  logic [DEN_W-1:0]     a_den_q;
  logic signed [63:0]   n3, n4;

  always_comb begin
    n3 = $signed({4'b0, data_i.sq12}) + $signed({4'b0, data_i.sq13})
       - $signed({4'b0, data_i.sq23});
    n4 = $signed({4'b0, data_i.sq12}) + $signed({4'b0, data_i.sq14})
       - $signed({4'b0, data_i.sq24});
    a_num3_d     = n3[63] ? Q1_W'(-n3) : Q1_W'(n3);
    a_num4_d     = n4[63] ? Q1_W'(-n4) : Q1_W'(n4);
    a_ctx_d      = '0;
    a_ctx_d.d12  = data_i.d12;
    a_ctx_d.d13  = data_i.d13;
    a_ctx_d.d14  = data_i.d14;
    a_ctx_d.sq13 = data_i.sq13;
    a_ctx_d.sq14 = data_i.sq14;
    a_ctx_d.sq34 = data_i.sq34;
    a_ctx_d.x3_s = n3[63];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx_q  <= a_ctx_d;
      a_num3_q <= a_num3_d;
      a_num4_q <= a_num4_d;
      a_s4_q   <= n4[63];
      a_den_q  <= {data_i.d12, 1'b0};
    end
  end

  // Both X quotients run side by side.
  logic             d3_v, d4_v;
  logic [Q1_W-1:0]  q3, q4;
  logic [CTX_W-1:0] d3_side;
  logic             d4_side;

  fafp_div #(.NUM_W(Q1_W), .DEN_W(DEN_W), .SIDE_W(CTX_W)) u_div3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_v_q), .num_i(a_num3_q), .den_i(a_den_q),
    .side_i(a_ctx_q), .valid_o(d3_v), .quo_o(q3), .side_o(d3_side)
  );

  fafp_div #(.NUM_W(Q1_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_v_q), .num_i(a_num4_q), .den_i(a_den_q),
    .side_i(a_s4_q), .valid_o(d4_v), .quo_o(q4), .side_o(d4_side)
  );

  // Stage B: range checks on the X values.
  logic b_v_q;
  ctx_t b_ctx_q, b_ctx_d;

  always_comb begin
    b_ctx_d      = ctx_t'(d3_side);
    b_ctx_d.x3_m = q3[CAP_W-1:0];
    b_ctx_d.e2   = (q3 > Q1_W'(b_ctx_d.d13));
    b_ctx_d.x4_s = d4_side;
    b_ctx_d.x4_m = q4[CAP_W-1:0];
    b_ctx_d.e4   = (q4 > Q1_W'(b_ctx_d.d14));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ctx_q <= b_ctx_d;
    end
  end

  // Stage C: products of the X values.
  logic c_v_q;
  ctx_t c_ctx_q, c_ctx_d;

  always_comb begin
    c_ctx_d       = b_ctx_q;
    c_ctx_d.px3   = SQ_W'(b_ctx_q.x3_m) * SQ_W'(b_ctx_q.x3_m);
    c_ctx_d.px4   = SQ_W'(b_ctx_q.x4_m) * SQ_W'(b_ctx_q.x4_m);
    c_ctx_d.pxx   = SQ_W'(b_ctx_q.x3_m) * SQ_W'(b_ctx_q.x4_m);
    c_ctx_d.pxx_s = b_ctx_q.x3_s ^ b_ctx_q.x4_s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ctx_q <= c_ctx_d;
    end
  end

  // Stage D: radicand for the third Y.
  logic            d_v_q;
  ctx_t            d_ctx_q;
  logic [SQ_W-1:0] d_rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ctx_q <= c_ctx_q;
      d_rad_q <= c_ctx_q.sq13 - c_ctx_q.px3;
    end
  end

  logic             r3_v;
  logic [CAP_W-1:0] r3_root;
  logic [CTX_W-1:0] r3_side;

  fafp_isqrt #(.RAD_W(SQ_W), .SIDE_W(CTX_W)) u_isqrt3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .rad_i(d_rad_q), .side_i(d_ctx_q),
    .valid_o(r3_v), .root_o(r3_root), .side_o(r3_side)
  );

  // Stage E: third Y and its square.
  logic e_v_q;
  ctx_t e_ctx_q, e_ctx_d;

  always_comb begin
    e_ctx_d     = ctx_t'(r3_side);
    e_ctx_d.y3  = r3_root;
    e_ctx_d.e3  = (r3_root == '0);
    e_ctx_d.py3 = SQ_W'(r3_root) * SQ_W'(r3_root);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ctx_q <= e_ctx_d;
    end
  end

  // Stage F: numerator of the fourth Y.
  logic               f_v_q;
  ctx_t               f_ctx_q, f_ctx_d;
  logic [Q2_W-1:0]    f_num_q, f_num_d;
  logic [DEN_W-1:0]   f_den_q;
  logic signed [65:0] t_xx, n5;

  always_comb begin
    t_xx = e_ctx_q.pxx_s ? -$signed({6'b0, e_ctx_q.pxx}) : $signed({6'b0, e_ctx_q.pxx});
    n5   = $signed({6'b0, e_ctx_q.sq14}) - $signed({6'b0, e_ctx_q.sq34})
         + $signed({6'b0, e_ctx_q.px3}) + $signed({6'b0, e_ctx_q.py3})
         - (t_xx <<< 1);
    f_ctx_d      = e_ctx_q;
    f_ctx_d.y4_s = n5[65];
    f_num_d      = n5[65] ? Q2_W'(-n5) : Q2_W'(n5);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctx_q <= f_ctx_d;
      f_num_q <= f_num_d;
      f_den_q <= {e_ctx_q.y3, 1'b0};
    end
  end

  logic             d5_v;
  logic [Q2_W-1:0]  q5;
  logic [CTX_W-1:0] d5_side;

  fafp_div #(.NUM_W(Q2_W), .DEN_W(DEN_W), .SIDE_W(CTX_W)) u_div5 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v_q), .num_i(f_num_q), .den_i(f_den_q),
    .side_i(f_ctx_q), .valid_o(d5_v), .quo_o(q5), .side_o(d5_side)
  );

  // Stage G: range check and square of the fourth Y.
  logic g_v_q;
  ctx_t g_ctx_q, g_ctx_d;

  always_comb begin
    g_ctx_d      = ctx_t'(d5_side);
    g_ctx_d.y4_m = q5[CAP_W-1:0];
    g_ctx_d.e4   = g_ctx_d.e4 || (q5 > Q2_W'(g_ctx_d.d14));
    g_ctx_d.py4  = SQ_W'(q5[CAP_W-1:0]) * SQ_W'(q5[CAP_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_ctx_q <= g_ctx_d;
    end
  end

  // Stage H: radicand for the fourth Z.
  logic               h_v_q;
  ctx_t               h_ctx_q, h_ctx_d;
  logic [SQ_W-1:0]    h_rad_q;
  logic signed [61:0] r4;

  always_comb begin
    r4 = $signed({2'b0, g_ctx_q.sq14}) - $signed({2'b0, g_ctx_q.px4})
       - $signed({2'b0, g_ctx_q.py4});
    h_ctx_d    = g_ctx_q;
    h_ctx_d.e4 = g_ctx_q.e4 || r4[61];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_ctx_q <= h_ctx_d;
      h_rad_q <= r4[SQ_W-1:0];
    end
  end

  logic             r4_v;
  logic [CAP_W-1:0] z4;
  logic [CTX_W-1:0] r4_side;
  ctx_t             j_ctx;

  fafp_isqrt #(.RAD_W(SQ_W), .SIDE_W(CTX_W)) u_isqrt4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_v_q), .rad_i(h_rad_q), .side_i(h_ctx_q),
    .valid_o(r4_v), .root_o(z4), .side_o(r4_side)
  );

  // Stage J: status, saturation and the output register.
  function automatic logic [16:0] sat_u16(input logic [CAP_W-1:0] m);
    if (m > CAP_W'(17'h0FFFF)) begin
      return {1'b1, 16'hFFFF};
    end
    return {1'b0, m[15:0]};
  endfunction

  function automatic logic [18:0] sat_s18(input logic s, input logic [CAP_W-1:0] m);
    logic [CAP_W-1:0] neg;
    neg = -m;
    if (!s && (m > CAP_W'(18'h1FFFF))) begin
      return {1'b1, 18'h1FFFF};
    end
    if (s && (m > CAP_W'(18'h20000))) begin
      return {1'b1, 18'h20000};
    end
    return {1'b0, (s ? neg[17:0] : m[17:0])};
  endfunction

  logic          out_v_q;
  logic [103:0]  out_data_q, out_data_d;
  status_e       out_st_q, out_st_d;
  logic [16:0]   sx, sy3, sz4;
  logic [18:0]   sx3, sx4, sy4;
  logic          any_sat;

  assign j_ctx = ctx_t'(r4_side);

  always_comb begin
    sx      = sat_u16(j_ctx.d12);
    sx3     = sat_s18(j_ctx.x3_s, j_ctx.x3_m);
    sy3     = sat_u16(j_ctx.y3);
    sx4     = sat_s18(j_ctx.x4_s, j_ctx.x4_m);
    sy4     = sat_s18(j_ctx.y4_s, j_ctx.y4_m);
    sz4     = sat_u16(z4);
    any_sat = sx[16] || sx3[18] || sy3[16] || sx4[18] || sy4[18] || sz4[16];
    priority if (j_ctx.d12 == '0) begin
      out_st_d = ST_ZERO_BASE;
    end else if (j_ctx.e2) begin
      out_st_d = ST_RAD3_NEG;
    end else if (j_ctx.e3) begin
      out_st_d = ST_Y3_ZERO;
    end else if (j_ctx.e4) begin
      out_st_d = ST_RAD4_NEG;
    end else if (any_sat) begin
      out_st_d = ST_SAT;
    end else begin
      out_st_d = ST_OK;
    end
    if ((out_st_d == ST_OK) || (out_st_d == ST_SAT)) begin
      out_data_d = {2'b00, sz4[15:0], sy4[17:0], sx4[17:0], sy3[15:0], sx3[17:0],
                    sx[15:0]};
    end else begin
      out_data_d = {88'b0, sx[15:0]};
    end
  end

  // The whole back end advances together whenever the output slot frees.
  assign en    = !out_v_q || m_axis_tready;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      h_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      a_v_q   <= valid_i;
      b_v_q   <= d3_v && d4_v;
      c_v_q   <= b_v_q;
      d_v_q   <= c_v_q;
      e_v_q   <= r3_v;
      f_v_q   <= e_v_q;
      g_v_q   <= d5_v;
      h_v_q   <= g_v_q;
      out_v_q <= r4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_st_q   <= out_st_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_st_q;

endmodule

/* src/four_anchor_closed_form_placement_core.sv */
// ----------------------------------------------------------------------------
// Four-anchor closed-form placement core
// Places four ranging anchors in a local frame from their six distances.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_axis channel carries the six pairwise distances,
//   DIST_BITS each, in millimetres. One result leaves on m_axis with the
//   anchor coordinates in tdata and a status code in tuser.
//   Throughput is one request per clock cycle while the output is not
//   stalled. The back end holds two 62-bit and one 64-bit bit-per-stage
//   dividers and the two 30-stage square root units in its pipeline.
//   The front end clamps and squares the distances and feeds a four-entry
//   queue; the back end pipeline advances whenever its output register is
//   empty or being taken. While the receiver stalls, the back end holds
//   and the queue keeps taking requests until it fills.
//   Reset clears all valid flags; the first request may follow at once.
// ----------------------------------------------------------------------------
module four_anchor_closed_form_placement_core #(
  parameter int DIST_BITS = 16,
  localparam int TDATA_W = ((6 * DIST_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // dist_12, dist_13, dist_23, dist_14,
                                             // dist_24, dist_34, zero fill
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [103:0]       m_axis_tdata,   // second_x, third_x, third_y, fourth_x,
                                             // fourth_y, fourth_z, zero fill
  output logic [2:0]         m_axis_tuser    // status
);
  import fafp_pkg::*;

  logic  fr_valid, fr_ready, q_valid, pop;
  dist_t fr_data, q_data;

  fafp_front #(.DIST_BITS(DIST_BITS)) u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .valid_o(fr_valid), .data_o(fr_data), .ready_i(fr_ready)
  );

  fafp_queue u_queue (
    .clk_i, .rst_ni, .valid_i(fr_valid), .ready_o(fr_ready), .data_i(fr_data),
    .valid_o(q_valid), .rd_i(pop), .data_o(q_data)
  );

  fafp_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .data_i(q_data), .pop_o(pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-anchor placement core testbench
// Drives distance sets into the core, predicts every placement result in
// 64-bit integer arithmetic and compares the results field by field in order.
// Both stream sides idle, partly at random, so that stalls fall on every pipeline phase.
// ----------------------------------------------------------------------------
module tb_top;
  import fafp_pkg::*;

  localparam int DIST_W     = 16;
  localparam int IN_W       = 96;
  localparam int N_RANDOM   = 600;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL       = 300;

  typedef struct {
    logic [15:0]        second_x;
    logic signed [17:0] third_x;
    logic [15:0]        third_y;
    logic signed [17:0] fourth_x;
    logic signed [17:0] fourth_y;
    logic [15:0]        fourth_z;
    status_e            status;
  } placement_t;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  class placement_scoreboard;
    placement_t expected_q[$];
    int         mismatches;
    int         checked;
    int         status_seen[8];

    function placement_t place(logic [IN_W-1:0] req);
      placement_t p;
      longint d12, d13, d23, d14, d24, d34;
      longint x3, y3, x4, y4, rad;
      d12 = req[15:0];
      d13 = req[31:16];
      d23 = req[47:32];
      d14 = req[63:48];
      d24 = req[79:64];
      d34 = req[95:80];
      p = '{second_x: d12[15:0], third_x: '0, third_y: '0, fourth_x: '0,
            fourth_y: '0, fourth_z: '0, status: ST_OK};
      if (d12 == 0) begin
        p.status = ST_ZERO_BASE;
        return p;
      end
      x3 = (d12 * d12 + d13 * d13 - d23 * d23) / (2 * d12);
      if ((x3 < 0 ? -x3 : x3) > d13) begin
        p.status = ST_RAD3_NEG;
        return p;
      end
      y3 = longint'(floor_root(longint'(d13 * d13 - x3 * x3)));
      if (y3 == 0) begin
        p.status = ST_Y3_ZERO;
        return p;
      end
      x4 = (d12 * d12 + d14 * d14 - d24 * d24) / (2 * d12);
      if ((x4 < 0 ? -x4 : x4) > d14) begin
        p.status = ST_RAD4_NEG;
        return p;
      end
      y4 = (d14 * d14 - d34 * d34 + x3 * x3 + y3 * y3 - 2 * x3 * x4) / (2 * y3);
      rad = d14 * d14 - x4 * x4 - y4 * y4;
      if ((y4 < 0 ? -y4 : y4) > d14 || rad < 0) begin
        p.status = ST_RAD4_NEG;
        return p;
      end
      // With 16-bit distances every coordinate fits its field, so no clamping.
      p.third_x  = x3[17:0];
      p.third_y  = y3[15:0];
      p.fourth_x = x4[17:0];
      p.fourth_y = y4[17:0];
      p.fourth_z = 16'(floor_root(rad));
      return p;
    endfunction

    function void note_request(logic [IN_W-1:0] req);
      expected_q.insert(expected_q.size(), place(req));
    endfunction

    function void fail_field(string name, longint e, longint a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 checked, name, e, a);
    endfunction

    function void check_result(logic [103:0] data, logic [2:0] user);
      placement_t e;
      placement_t a;
      a.second_x = data[15:0];
      a.third_x  = data[33:16];
      a.third_y  = data[49:34];
      a.fourth_x = data[67:50];
      a.fourth_y = data[85:68];
      a.fourth_z = data[101:86];
      a.status   = status_e'(user);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending");
        return;
      end
      e = expected_q.pop_front();
      if (a.second_x != e.second_x) fail_field("second_x", e.second_x, a.second_x);
      if (a.third_x  != e.third_x)  fail_field("third_x", e.third_x, a.third_x);
      if (a.third_y  != e.third_y)  fail_field("third_y", e.third_y, a.third_y);
      if (a.fourth_x != e.fourth_x) fail_field("fourth_x", e.fourth_x, a.fourth_x);
      if (a.fourth_y != e.fourth_y) fail_field("fourth_y", e.fourth_y, a.fourth_y);
      if (a.fourth_z != e.fourth_z) fail_field("fourth_z", e.fourth_z, a.fourth_z);
      if (a.status   != e.status)   fail_field("status", e.status, a.status);
      status_seen[e.status]++;
      checked++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [103:0]       m_axis_tdata;
  logic [2:0]         m_axis_tuser;

  placement_scoreboard sb = new();
  int  cycle_cnt;
  int  idle_cnt;
  int  n_directed;
  int  n_geometric;
  int  n_noise;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  four_anchor_closed_form_placement_core #(.DIST_BITS(DIST_W)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // The receiver cycles through phases: always ready, light and heavy random
  // stalls, and a fixed periodic stall.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case ((cycle_cnt >> 7) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2: m_axis_tready <= ((cycle_cnt % 11) < 7);
      default: m_axis_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 sb.expected_q.size());
        $display("four_anchor_closed_form_placement_core test failed");
        $finish;
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_dists(int a, int b, int c, int d, int e, int f);
    return {16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic int span(longint dx, longint dy, longint dz);
    longint unsigned r;
    r = floor_root(longint'(dx * dx + dy * dy + dz * dz)) + $urandom_range(0, 1);
    return (r > 65535) ? 65535 : int'(r);
  endfunction

  // A distance set measured from a real anchor layout, so that most sets get
  // past the early error checks.
  function automatic logic [IN_W-1:0] layout_dists();
    int rng, x2, x3, y3, x4, y4, z4;
    case ($urandom_range(0, 3))
      0: rng = 20;
      1: rng = 500;
      default: rng = 15000;
    endcase
    x2 = $urandom_range(1, 2 * rng);
    x3 = int'($urandom_range(0, 2 * rng)) - rng;
    y3 = int'($urandom_range(0, 2 * rng)) - rng;
    x4 = int'($urandom_range(0, 2 * rng)) - rng;
    y4 = int'($urandom_range(0, 2 * rng)) - rng;
    z4 = int'($urandom_range(0, 2 * rng)) - rng;
    return pack_dists(span(x2, 0, 0), span(x3, y3, 0), span(x3 - x2, y3, 0),
                      span(x4, y4, z4), span(x4 - x2, y4, z4),
                      span(x4 - x3, y4 - y3, z4));
  endfunction

  function automatic logic [IN_W-1:0] noise_dists();
    logic [IN_W-1:0] v;
    v = {$urandom, $urandom, $urandom};
    // Some fields pinned to an extreme to reach the boundaries more often.
    for (int i = 0; i < 6; i++)
      case ($urandom_range(0, 7))
        0: v[i*16 +: 16] = '0;
        1: v[i*16 +: 16] = '1;
        default: ;
      endcase
    return v;
  endfunction

  int burst_left;

  task automatic send_request(logic [IN_W-1:0] req);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    logic [IN_W-1:0] directed_q[$];
    directed_q = '{
      pack_dists(0, 0, 0, 0, 0, 0),
      pack_dists(0, 65535, 65535, 65535, 65535, 65535),
      pack_dists(65535, 65535, 65535, 65535, 65535, 65535),
      pack_dists(1, 0, 100, 5, 5, 5),
      pack_dists(10, 10, 0, 7, 7, 7),
      pack_dists(1000, 1000, 1414, 1, 1414, 1414),
      pack_dists(1000, 1000, 1414, 1000, 1000, 5),
      pack_dists(1000, 1000, 1414, 1000, 1414, 1414),
      pack_dists(1000, 943, 1578, 700, 900, 1200),
      pack_dists(65535, 65535, 0, 100, 100, 100),
      pack_dists(1, 65535, 65535, 65535, 65535, 0),
      pack_dists(1, 1, 1, 1, 1, 1),
      {6{16'hAAAA}},
      {6{16'h5555}},
      pack_dists(2, 1, 1, 1, 1, 1),
      pack_dists(65535, 1, 65535, 65535, 0, 65535)
    };
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_q[i]) begin
      send_request(directed_q[i]);
      n_directed++;
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        send_request(layout_dists());
        n_geometric++;
      end else begin
        send_request(noise_dists());
        n_noise++;
      end
    end
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    $display("covered %0d directed, %0d layout and %0d noise distance sets, %0d results",
             n_directed, n_geometric, n_noise, sb.checked);
    $display("status mix: ok %0d, zero base %0d, third neg %0d, y3 zero %0d, fourth neg %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_ZERO_BASE],
             sb.status_seen[ST_RAD3_NEG], sb.status_seen[ST_Y3_ZERO],
             sb.status_seen[ST_RAD4_NEG]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("four_anchor_closed_form_placement_core test passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("four_anchor_closed_form_placement_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fafp_pkg.sv
src/fafp_front.sv
src/fafp_queue.sv
src/fafp_div.sv
src/fafp_isqrt.sv
src/fafp_back.sv
src/four_anchor_closed_form_placement_core.sv
tb/tb_top.sv
